/* rtl/tps_pkg.sv */
// Shared widths, opcode and register codes, and the result record of the
// parent-selection block. No dependencies.
`default_nettype none

package tps_pkg;

   localparam int OP_W       = 2;
   localparam int ADDR_W     = 16;
   localparam int RANK_W     = 8;
   localparam int SIG_W      = 16;
   localparam int SEQ_W      = 8;
   localparam int FAIL_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // event codes
   localparam logic [OP_W-1:0] OpBeacon   = 2'd0;
   localparam logic [OP_W-1:0] OpResponse = 2'd1;
   localparam logic [OP_W-1:0] OpTimeout  = 2'd2;
   localparam logic [OP_W-1:0] OpValve    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CsrOwnAddress = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CsrFailLimit  = 1'b1;

   localparam logic [FAIL_W-1:0] FailLimitReset = 4'd3;

   typedef struct packed {
      logic              send_rank_reply;
      logic              rank_was_reset;
      logic              parent_changed;
      logic              valve_local;
      logic              valve_forward;
      logic              valve_duplicate;
      logic [RANK_W-1:0] rank_after;
      logic [ADDR_W-1:0] current_parent;
   } result_type;

endpackage

`default_nettype wire

/* rtl/tree_parent_selection.sv */
// Top level of the parent-selection block: input register, event logic,
// node state and result register. Depends on tps_pkg.
`default_nettype none

// Takes one event per clock while req_stall is low, and gives one result beat
// per event, in order. An accepted event sits in the input register, is
// evaluated against the node state and lands in the result register, where
// it is offered until taken; the state is updated as the event moves into
// the result register, ready for the event right behind it. The input only
// stalls while both registers are full and the result beat is itself
// stalled.
// Received ranks above RANK_MAX are clamped to RANK_MAX, which means
// unranked. Registers are written through the csr_ port; the user must write
// them only while no event is in flight, as the block does not enforce it.
module tree_parent_selection
   import tps_pkg::*;
#(
   parameter int RANK_MAX = 255
) (
   input  wire                     clock,
   input  wire                     reset,

   input  wire                     csr_write,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CSR_DATA_W-1:0]    csr_wdata,

   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire [OP_W-1:0]          req_opcode,
   input  wire [ADDR_W-1:0]        req_sender_address,
   input  wire [RANK_W-1:0]        req_peer_rank,
   input  wire [SIG_W-1:0]         req_signal_strength,
   input  wire [SEQ_W-1:0]         req_valve_sequence,
   input  wire [ADDR_W-1:0]        req_valve_target,

   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_send_rank_reply,
   output logic                    rsp_rank_was_reset,
   output logic                    rsp_parent_changed,
   output logic                    rsp_valve_local,
   output logic                    rsp_valve_forward,
   output logic                    rsp_valve_duplicate,
   output logic [RANK_W-1:0]       rsp_current_rank,
   output logic [ADDR_W-1:0]       rsp_current_parent
);

   localparam logic [RANK_W-1:0] RankTop = RANK_W'(RANK_MAX);

   // configuration
   logic [ADDR_W-1:0] own_address_ff, own_address_in;
   logic [FAIL_W-1:0] fail_limit_ff, fail_limit_in;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] sender_ff, sender_in;
   logic [RANK_W-1:0] prank_ff, prank_in;
   logic [SIG_W-1:0]  sig_ff, sig_in;
   logic [SEQ_W-1:0]  vseq_ff, vseq_in;
   logic [ADDR_W-1:0] vtarget_ff, vtarget_in;

   // node state
   logic [RANK_W-1:0] node_rank_ff, node_rank_in;
   logic [RANK_W-1:0] held_rank_ff, held_rank_in;
   logic [ADDR_W-1:0] parent_link_ff, parent_link_in;
   logic [SIG_W-1:0]  parent_signal_ff, parent_signal_in;
   logic [FAIL_W-1:0] fail_count_ff, fail_count_in;
   logic [SEQ_W-1:0]  last_vseq_ff, last_vseq_in;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic accept;
   logic advance;
   logic drop;
   logic adopt;

   // ---------------------------------------------------------------- handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // ---------------------------------------------------------------- config
   always_comb begin
      own_address_in = own_address_ff;
      fail_limit_in  = fail_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CsrOwnAddress: own_address_in = csr_wdata[ADDR_W-1:0];
            CsrFailLimit:  fail_limit_in  = csr_wdata[FAIL_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- input stage
   always_comb begin
      op_in      = op_ff;
      sender_in  = sender_ff;
      prank_in   = prank_ff;
      sig_in     = sig_ff;
      vseq_in    = vseq_ff;
      vtarget_in = vtarget_ff;
      if (accept) begin
         op_in      = req_opcode;
         sender_in  = req_sender_address;
         prank_in   = (req_peer_rank > RankTop) ? RankTop : req_peer_rank;
         sig_in     = req_signal_strength;
         vseq_in    = req_valve_sequence;
         vtarget_in = req_valve_target;
      end
   end

   // ---------------------------------------------------------------- event logic
   always_comb begin
      drop             = 1'b0;
      adopt            = 1'b0;
      node_rank_in     = node_rank_ff;
      held_rank_in     = held_rank_ff;
      parent_link_in   = parent_link_ff;
      parent_signal_in = parent_signal_ff;
      fail_count_in    = fail_count_ff;
      last_vseq_in     = last_vseq_ff;
      rsp_in           = rsp_ff;

      if (advance) begin
         rsp_in = '0;
         unique case (op_ff)
            OpBeacon: begin
               if (node_rank_ff != RankTop) begin
                  if (sender_ff == parent_link_ff && prank_ff == RankTop) begin
                     drop = 1'b1;
                  end else if (prank_ff > node_rank_ff) begin
                     rsp_in.send_rank_reply = 1'b1;
                  end
               end
            end
            OpResponse: begin
               if (node_rank_ff == RankTop && prank_ff != RankTop) begin
                  adopt = 1'b1;
               end else if (sender_ff == parent_link_ff) begin
                  if (prank_ff == RankTop || prank_ff > held_rank_ff) begin
                     drop = 1'b1;
                  end else begin
                     parent_signal_in = sig_ff;
                  end
               end else if (node_rank_ff > prank_ff && sig_ff > parent_signal_ff) begin
                  adopt = 1'b1;
               end
            end
            OpTimeout: begin
               if (fail_count_ff < fail_limit_ff) begin
                  fail_count_in = fail_count_ff + FAIL_W'(1);
               end else begin
                  fail_count_in = '0;
                  drop          = 1'b1;
               end
            end
            OpValve: begin
               if (last_vseq_ff == vseq_ff) begin
                  rsp_in.valve_duplicate = 1'b1;
               end else begin
                  last_vseq_in = vseq_ff;
                  if (vtarget_ff == own_address_ff) begin
                     rsp_in.valve_local = 1'b1;
                  end else begin
                     rsp_in.valve_forward = 1'b1;
                  end
               end
            end
         endcase

         if (drop) begin
            node_rank_in   = RankTop;
            held_rank_in   = RankTop;
            parent_link_in = '0;
         end
         if (adopt) begin
            // prank is below the current rank here, so +1 cannot wrap
            node_rank_in     = prank_ff + RANK_W'(1);
            held_rank_in     = prank_ff;
            parent_link_in   = sender_ff;
            parent_signal_in = sig_ff;
         end

         rsp_in.rank_was_reset = drop;
         rsp_in.parent_changed = adopt;
         rsp_in.rank_after     = node_rank_in;
         rsp_in.current_parent = parent_link_in;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= '0;
         fail_limit_ff    <= FailLimitReset;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         node_rank_ff     <= RankTop;
         held_rank_ff     <= RankTop;
         parent_link_ff   <= '0;
         parent_signal_ff <= '0;
         fail_count_ff    <= '0;
         last_vseq_ff     <= '0;
      end else begin
         own_address_ff   <= own_address_in;
         fail_limit_ff    <= fail_limit_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         node_rank_ff     <= node_rank_in;
         held_rank_ff     <= held_rank_in;
         parent_link_ff   <= parent_link_in;
         parent_signal_ff <= parent_signal_in;
         fail_count_ff    <= fail_count_in;
         last_vseq_ff     <= last_vseq_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      sender_ff  <= sender_in;
      prank_ff   <= prank_in;
      sig_ff     <= sig_in;
      vseq_ff    <= vseq_in;
      vtarget_ff <= vtarget_in;
      rsp_ff     <= rsp_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_rank_reply = rsp_ff.send_rank_reply;
   assign rsp_rank_was_reset  = rsp_ff.rank_was_reset;
   assign rsp_parent_changed  = rsp_ff.parent_changed;
   assign rsp_valve_local     = rsp_ff.valve_local;
   assign rsp_valve_forward   = rsp_ff.valve_forward;
   assign rsp_valve_duplicate = rsp_ff.valve_duplicate;
   assign rsp_current_rank    = rsp_ff.rank_after;
   assign rsp_current_parent  = rsp_ff.current_parent;

`ifndef SYNTH
   // a reset beat always reports the node as unranked with no parent
   a_reset_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rank_was_reset |->
         rsp_ff.rank_after == RankTop && rsp_ff.current_parent == '0)
      else $error("reset beat does not show an unranked node");

   // valve outcome is exclusive and never mixed with tree flags
   a_valve_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         $onehot0({rsp_ff.valve_local, rsp_ff.valve_forward, rsp_ff.valve_duplicate,
                   rsp_ff.rank_was_reset, rsp_ff.parent_changed,
                   rsp_ff.send_rank_reply}))
      else $error("more than one outcome flag in a result beat");

   // an event moves into the result register only when the previous beat has gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_ff) && rsp_valid_ff)
      else $error("stalled result beat was overwritten");

   // state only moves when an event is retired
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(node_rank_ff) && $stable(parent_link_ff)
                   && $stable(last_vseq_ff))
      else $error("node state changed without an event");
`endif

endmodule

`default_nettype wire
